// ===== hdl/sote_pkg.sv =====
// Shared constants and types for the step-offset template engine.
package sote_pkg;

  // Amplitude table geometry
  localparam int unsigned AMP_DEPTH = 1024;
  localparam int unsigned AMP_AW    = $clog2(AMP_DEPTH);
  localparam int unsigned VAL_W     = 48;
  // One table word: flag on top of the Q32.16 amplitude
  localparam int unsigned ENTRY_W   = VAL_W + 1;

  // Field widths
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SFLAG_W   = 8;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Request actions
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_ADD     = 2'd2,
    ACT_PROJECT = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FLAGS   = 2'd2;

endpackage

// ===== hdl/sote_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sote_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/step_offset_template_engine.sv =====
// Top level of the step-offset template engine: table access, offset add and projection.
// Timing: a write request updates the table at its accepting edge; a read or add result
//   is registered in execute (RAM read at acceptance); a stalled result holds its execute.
// Throughput: one write per cycle while idle; a read, add or project stalls new requests
//   until its execute ends, set by read-modify-write through the single amplitude RAM.
// Reset: step position, current amplitude index, control and config registers return to
//   defaults at once; the amplitude table is not cleared and holds garbage until written.
module step_offset_template_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sote_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sote_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  // Request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic [sote_pkg::IDX_W-1:0]           index_i,
  input  logic                                 view_start_i,
  input  logic signed [sote_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [sote_pkg::SFLAG_W-1:0]         sample_flag_i,
  input  logic signed [sote_pkg::VAL_W-1:0]    amp_value_i,
  input  logic                                 amp_flag_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sote_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic signed [sote_pkg::VAL_W-1:0]    read_value_o,
  output logic                                 read_flag_o
);

  localparam int unsigned AW   = sote_pkg::AMP_AW;
  localparam int unsigned VW   = sote_pkg::VAL_W;
  localparam int unsigned SW   = sote_pkg::SAMPLE_W;
  localparam int unsigned IW   = sote_pkg::IDX_W;
  localparam int unsigned STW  = sote_pkg::STEP_W;
  localparam int unsigned SUMW = VW + 1;

  localparam logic signed [SUMW-1:0] SAT32_MAX = SUMW'(64'sd2147483647);
  localparam logic signed [SUMW-1:0] SAT32_MIN = -SUMW'(64'sd2147483648);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Configuration registers
  logic [STW-1:0]                   step_length_q;
  logic [sote_pkg::SFLAG_W-1:0]     flag_mask_q;
  logic                             use_flags_q;

  // Step tracking
  logic [STW-1:0]                   step_pos_q, step_pos_d;
  logic [IW-1:0]                    cur_idx_q, cur_idx_d;

  // Item held for the execute cycle
  state_e                           state_q;
  sote_pkg::action_e                act_q;
  logic [AW-1:0]                    addr_q;
  logic                             in_range_q;
  logic                             keep_q;
  logic signed [SW-1:0]             sample_q;

  // Result register
  logic                             out_valid_q;
  logic signed [SW-1:0]             out_sample_q;
  logic signed [VW-1:0]             read_value_q;
  logic                             read_flag_q;

  // RAM ports
  logic                             ram_we, ram_re;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [sote_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;

  sote_pkg::action_e                act_in;
  logic                             accept;
  logic                             is_sample;
  logic [IW-1:0]                    cur_use;
  logic [IW-1:0]                    req_idx;
  logic                             req_in_range;
  logic [STW-1:0]                   pos_base, pos_inc;

  logic signed [VW-1:0]             ent_val;
  logic                             ent_flag;
  logic                             usable;
  logic signed [SUMW-1:0]           add_sum, proj_sum;
  logic signed [SW-1:0]             add_sat;
  logic signed [VW-1:0]             proj_sat;
  logic                             out_free;
  logic                             exec_done;

  assign act_in     = sote_pkg::action_e'(action_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_sample  = (act_in == sote_pkg::ACT_ADD) || (act_in == sote_pkg::ACT_PROJECT);

  // Select the entry this request touches
  assign cur_use      = view_start_i ? index_i : cur_idx_q;
  assign req_idx      = is_sample ? cur_use : index_i;
  assign req_in_range = (32'(req_idx) < 32'(sote_pkg::AMP_DEPTH));

  // Advance the step counter on every sample request
  assign pos_base = view_start_i ? '0 : step_pos_q;
  assign pos_inc  = pos_base + STW'(1);

  always_comb begin
    step_pos_d = step_pos_q;
    cur_idx_d  = cur_idx_q;
    if (accept && is_sample) begin
      if ((pos_inc >= step_length_q) || (pos_inc == '0)) begin
        step_pos_d = '0;
        cur_idx_d  = cur_use + IW'(1);
      end else begin
        step_pos_d = pos_inc;
        cur_idx_d  = cur_use;
      end
    end
  end

  // Execute-cycle arithmetic on the entry read back from the RAM
  assign ent_val  = ram_rdata[VW-1:0];
  assign ent_flag = ram_rdata[VW];
  assign usable   = in_range_q && !ent_flag;

  assign add_sum  = SUMW'(sample_q) + SUMW'(ent_val);
  assign proj_sum = SUMW'(ent_val) + SUMW'(sample_q);

  always_comb begin
    if (add_sum > SAT32_MAX) begin
      add_sat = SW'(SAT32_MAX);
    end else if (add_sum < SAT32_MIN) begin
      add_sat = SW'(SAT32_MIN);
    end else begin
      add_sat = add_sum[SW-1:0];
    end
  end

  // Saturate to 48 bits when the two top bits disagree
  always_comb begin
    if (proj_sum[SUMW-1] != proj_sum[VW-1]) begin
      proj_sat = proj_sum[SUMW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      proj_sat = proj_sum[VW-1:0];
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign exec_done = (state_q == ST_EXEC) &&
                     ((act_q == sote_pkg::ACT_PROJECT) || out_free);

  // RAM access: writes at acceptance, projection write-back in execute
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(index_i);
    ram_wdata = {amp_flag_i, amp_value_i};
    if (state_q == ST_EXEC) begin
      ram_we    = (act_q == sote_pkg::ACT_PROJECT) && usable && keep_q;
      ram_waddr = addr_q;
      ram_wdata = {ent_flag, proj_sat};
    end else if (accept && (act_in == sote_pkg::ACT_WRITE)) begin
      ram_we = req_in_range;
    end
  end

  assign ram_re    = accept && (act_in != sote_pkg::ACT_WRITE) && req_in_range;
  assign ram_raddr = AW'(req_idx);

  sote_ram #(
    .Width (sote_pkg::ENTRY_W),
    .Depth (sote_pkg::AMP_DEPTH)
  ) u_amp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_length_q <= STW'(1);
      flag_mask_q   <= '0;
      use_flags_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sote_pkg::CFG_STEP_LENGTH: step_length_q <= cfg_data_i[STW-1:0];
        sote_pkg::CFG_FLAG_MASK:   flag_mask_q   <= cfg_data_i[sote_pkg::SFLAG_W-1:0];
        sote_pkg::CFG_USE_FLAGS:   use_flags_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state, step tracking and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_pos_q  <= '0;
      cur_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_pos_q <= step_pos_d;
      cur_idx_q  <= cur_idx_d;
      // Raise valid when a result loads, drop it once taken
      if (exec_done && (act_q != sote_pkg::ACT_PROJECT)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && (act_in != sote_pkg::ACT_WRITE)) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold the request for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= act_in;
      addr_q     <= AW'(req_idx);
      in_range_q <= req_in_range;
      sample_q   <= sample_i;
      keep_q     <= !(use_flags_q && ((sample_flag_i & flag_mask_q) != '0));
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (exec_done && (act_q != sote_pkg::ACT_PROJECT)) begin
      if (act_q == sote_pkg::ACT_READ) begin
        out_sample_q <= '0;
        read_value_q <= in_range_q ? ent_val : '0;
        read_flag_q  <= in_range_q ? ent_flag : 1'b1;
      end else begin
        out_sample_q <= usable ? add_sat : sample_q;
        read_value_q <= '0;
        read_flag_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign read_value_o = read_value_q;
  assign read_flag_o  = read_flag_q;

endmodule
